@@ src/tdc_subevent_word_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// TDC sub-event word decoder assertion macros
// Property wrappers used by the checker file of the decoder.
// ----------------------------------------------------------------------------
`ifndef TDC_SUBEVENT_WORD_DECODER_MACROS_SVH
`define TDC_SUBEVENT_WORD_DECODER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TDCSWD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies an expectation in the next cycle.
`define TDCSWD_ASSERT_NEXT(label, cond, expct, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
        else $error(msg);

`endif

@@ src/tdcswd_pkg.sv @@
// ----------------------------------------------------------------------------
// TDC sub-event word decoder package
// Constants, result record and helper functions of the decoder.
// ----------------------------------------------------------------------------
package tdcswd_pkg;

    localparam int MAX_BANK_WORDS_DEF = 65536;

    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int KIND_W      = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = 6 * WORD_W + HALF_W + 2;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int SLOTS      = 3;

    localparam int IDX_SIZE    = 2;
    localparam int IDX_DECODE  = 3;
    localparam int IDX_SUBEVT  = 4;
    localparam int IDX_TRIGGER = 5;
    localparam int IDX_WALK    = 6;

    localparam logic [WORD_W-1:0] TRAILER_WORD = 32'h0001_5555;
    localparam logic [WORD_W-1:0] TOP3_MASK    = 32'he000_0000;
    localparam logic [WORD_W-1:0] EPOCH_TAG    = 32'h6000_0000;
    localparam logic [WORD_W-1:0] HIT_TAG      = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_MASK     = 32'h0000_ffff;
    localparam logic [WORD_W-1:0] HIGH_MASK    = 32'hffff_0000;
    localparam logic [WORD_W-1:0] HDR_LO_MIN   = 32'h0000_0100;
    localparam logic [WORD_W-1:0] HDR_LO_MAX   = 32'h0000_0403;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVENT   = 2'd0,
        KIND_MEAS    = 2'd1,
        KIND_TRAILER = 2'd2,
        KIND_EARLY   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_FPGA_HDR = 2'd0,
        PH_TDC_HDR  = 2'd1,
        PH_DATA     = 2'd2,
        PH_DONE     = 2'd3
    } phase_t;

    typedef struct packed {
        kind_t               kind;
        logic [WORD_W-1:0]   fpga_header;
        logic [WORD_W-1:0]   tdc_header;
        logic [WORD_W-1:0]   epoch_value;
        logic [WORD_W-1:0]   tdc_data;
        logic [HALF_W-1:0]   subevent_id;
        logic [WORD_W-1:0]   trigger_value;
        logic [WORD_W-1:0]   decoding_value;
        logic                trailer_ok;
        logic                swapped;
        logic                result_last;
    } result_t;

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic header_ok(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] lo;
        lo = w & LOW_MASK;
        return (lo[15:8] >= HDR_LO_MIN[15:8]) && (lo[15:8] <= HDR_LO_MAX[15:8])
            && (lo[7:0] <= HDR_LO_MAX[7:0]);
    endfunction

endpackage

@@ src/tdc_subevent_word_decoder.sv @@
// ----------------------------------------------------------------------------
// TDC sub-event word decoder
// Walks a readout bank word by word and emits event header, measurement,
// trailer check and early end results.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata                 | tuser | tlast
//  s_*     | in  | bank_word             | -     | bank_last
//  m_*     | out | result fields         | kind  | result_last
//
// One bank word is taken per cycle while s_tready is high; the k results of a
// word leave the four-entry result queue one per cycle while m_tready is high.
// A word is registered on its transfer and its results enter the queue in the
// following cycle, from where the first result can leave.
// Reset clears all control state at once; there is no clearing pass.
// A stalled output holds the queue, and input is taken while at most one
// result remains queued after the pending word is written.
// ----------------------------------------------------------------------------
module tdc_subevent_word_decoder #(
    parameter int MAX_BANK_WORDS = tdcswd_pkg::MAX_BANK_WORDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // bank_word[31:0]
    input  logic [tdcswd_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fpga_header[31:0], tdc_header[63:32], epoch_value[95:64],
    // tdc_data[127:96], subevent_id[143:128], trigger_value[175:144],
    // decoding_value[207:176], trailer_ok[208], swapped[209], zero pad
    output logic [tdcswd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // kind[1:0]
    output logic [tdcswd_pkg::KIND_W-1:0]      m_tuser,
    output logic                               m_tlast
);
    import tdcswd_pkg::*;

    localparam int IDX_W = $clog2(MAX_BANK_WORDS + 1);
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_BANK_WORDS);

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_last_reg;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] held_reg, held_next;
    logic              swap_reg, swap_next;
    logic [WORD_W-1:0] dec_reg, dec_next;
    logic [HALF_W-1:0] sub_reg, sub_next;
    phase_t            phase_reg, phase_next;
    logic [HALF_W-1:0] left_reg, left_next;
    logic [WORD_W-1:0] fpga_reg, fpga_next;
    logic [WORD_W-1:0] tdch_reg, tdch_next;
    logic [WORD_W-1:0] epoch_reg, epoch_next;
    logic              seen_reg, seen_next;

    result_t           fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]  count_reg, count_next;

    logic              in_range, clear, is_size, is_decode, is_subevt, is_trigger;
    logic              walk_en, swap_new, swap_cur, hdr_ok, try_hdr, meas_valid;
    logic              trail_now, early_now, pop;
    logic [WORD_W-1:0] w, held_cur;
    logic [29:0]       size_idx;
    logic [HALF_W-1:0] left_dec;
    result_t           res_a, res_b, res_c, base;
    result_t           slot [SLOTS];
    logic [1:0]        wr_n;

    assign in_range   = in_valid_reg && (idx_reg < IDX_LIMIT);
    assign clear      = in_valid_reg && in_last_reg;
    assign is_size    = in_range && (idx_reg == IDX_W'(IDX_SIZE));
    assign is_decode  = in_range && (idx_reg == IDX_W'(IDX_DECODE));
    assign is_subevt  = in_range && (idx_reg == IDX_W'(IDX_SUBEVT));
    assign is_trigger = in_range && (idx_reg == IDX_W'(IDX_TRIGGER));
    assign walk_en    = in_range && (idx_reg >= IDX_W'(IDX_WALK));

    assign swap_new = !(in_word_reg[0] && !in_word_reg[31]);
    assign swap_cur = is_decode ? swap_new : swap_reg;
    assign w        = swap_cur ? swap32(in_word_reg) : in_word_reg;
    assign held_cur = (is_decode && swap_new) ? swap32(held_reg) : held_reg;
    assign size_idx = held_cur[31:2];

    assign hdr_ok   = header_ok(w);
    assign left_dec = left_reg - HALF_W'(1);
    assign try_hdr  = walk_en && ((phase_reg == PH_FPGA_HDR)
                   || ((phase_reg == PH_TDC_HDR) && (left_reg == '0))
                   || ((phase_reg == PH_DATA) && (left_dec == '0)));
    assign meas_valid = walk_en && (phase_reg == PH_DATA) && ((w & TOP3_MASK) == HIT_TAG);

    assign trail_now = in_range && (idx_reg >= IDX_W'(IDX_DECODE)) && !seen_reg
                    && ((size_idx == 30'(idx_reg)) || (is_decode && (size_idx < 30'd3)));
    assign early_now = clear && !seen_reg && !trail_now;

    always_comb
    begin
        phase_next = phase_reg;
        if (walk_en)
        begin
            unique case (phase_reg)
                PH_FPGA_HDR: phase_next = hdr_ok ? PH_TDC_HDR : PH_DONE;
                PH_TDC_HDR:
                begin
                    if (left_reg == '0)
                        phase_next = hdr_ok ? PH_TDC_HDR : PH_DONE;
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (left_dec == '0)
                        phase_next = hdr_ok ? PH_TDC_HDR : PH_DONE;
                end
                PH_DONE: phase_next = PH_DONE;
                default: phase_next = PH_DONE;
            endcase
        end
        if (clear)
            phase_next = PH_FPGA_HDR;
    end

    always_comb
    begin
        left_next  = left_reg;
        fpga_next  = fpga_reg;
        tdch_next  = tdch_reg;
        epoch_next = epoch_reg;
        if (walk_en && (phase_reg == PH_TDC_HDR))
            tdch_next = w;
        if (walk_en && (phase_reg == PH_DATA))
        begin
            left_next = left_dec;
            if ((w & TOP3_MASK) == EPOCH_TAG)
                epoch_next = w;
        end
        if (try_hdr && hdr_ok)
        begin
            fpga_next  = w;
            left_next  = HALF_W'((w & HIGH_MASK) >> HALF_W);
            epoch_next = '0;
        end
        if (clear)
        begin
            left_next  = '0;
            fpga_next  = '0;
            tdch_next  = '0;
            epoch_next = '0;
        end
    end

    always_comb
    begin
        idx_next  = in_range ? idx_reg + IDX_W'(1) : idx_reg;
        held_next = is_size ? in_word_reg : held_cur;
        swap_next = swap_cur;
        dec_next  = is_decode ? w : dec_reg;
        sub_next  = is_subevt ? w[HALF_W-1:0] : sub_reg;
        seen_next = seen_reg || trail_now;
        if (clear)
        begin
            idx_next  = '0;
            held_next = '0;
            swap_next = 1'b0;
            dec_next  = '0;
            sub_next  = '0;
            seen_next = 1'b0;
        end
    end

    always_comb
    begin
        base         = '0;
        base.swapped = swap_cur;

        res_a = base;
        if (is_trigger)
        begin
            res_a.kind           = KIND_EVENT;
            res_a.subevent_id    = sub_reg;
            res_a.trigger_value  = w;
            res_a.decoding_value = dec_reg;
        end
        else
        begin
            res_a.kind        = KIND_MEAS;
            res_a.fpga_header = fpga_reg;
            res_a.tdc_header  = tdch_reg;
            res_a.epoch_value = epoch_reg;
            res_a.tdc_data    = w;
        end

        res_b            = base;
        res_b.kind       = KIND_TRAILER;
        res_b.trailer_ok = (size_idx == 30'(idx_reg)) && (w == TRAILER_WORD);

        res_c      = base;
        res_c.kind = KIND_EARLY;

        wr_n = '0;
        for (int i = 0; i < SLOTS; i++)
            slot[i] = base;
        if (is_trigger || meas_valid)
        begin
            slot[wr_n] = res_a;
            wr_n       = wr_n + 2'd1;
        end
        if (trail_now)
        begin
            slot[wr_n] = res_b;
            wr_n       = wr_n + 2'd1;
        end
        if (early_now)
        begin
            slot[wr_n] = res_c;
            wr_n       = wr_n + 2'd1;
        end
        for (int i = 0; i < SLOTS; i++)
            slot[i].result_last = ((2'(i) + 2'd1) == wr_n);
    end

    assign m_tvalid   = (count_reg != '0);
    assign pop        = m_tvalid && m_tready;
    assign count_next = count_reg - {{FIFO_AW{1'b0}}, pop} + {1'b0, wr_n};
    assign s_tready   = (count_next <= (FIFO_AW + 1)'(1));

    assign m_tuser = fifo_mem[rd_ptr_reg].kind;
    assign m_tlast = fifo_mem[rd_ptr_reg].result_last;
    assign m_tdata = {{OUT_PAD_W{1'b0}},
                      fifo_mem[rd_ptr_reg].swapped,
                      fifo_mem[rd_ptr_reg].trailer_ok,
                      fifo_mem[rd_ptr_reg].decoding_value,
                      fifo_mem[rd_ptr_reg].trigger_value,
                      fifo_mem[rd_ptr_reg].subevent_id,
                      fifo_mem[rd_ptr_reg].tdc_data,
                      fifo_mem[rd_ptr_reg].epoch_value,
                      fifo_mem[rd_ptr_reg].tdc_header,
                      fifo_mem[rd_ptr_reg].fpga_header};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            idx_reg      <= '0;
            held_reg     <= '0;
            swap_reg     <= 1'b0;
            dec_reg      <= '0;
            sub_reg      <= '0;
            phase_reg    <= PH_FPGA_HDR;
            left_reg     <= '0;
            fpga_reg     <= '0;
            tdch_reg     <= '0;
            epoch_reg    <= '0;
            seen_reg     <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= s_tvalid && s_tready;
            if (in_valid_reg)
            begin
                idx_reg   <= idx_next;
                held_reg  <= held_next;
                swap_reg  <= swap_next;
                dec_reg   <= dec_next;
                sub_reg   <= sub_next;
                phase_reg <= phase_next;
                left_reg  <= left_next;
                fpga_reg  <= fpga_next;
                tdch_reg  <= tdch_next;
                epoch_reg <= epoch_next;
                seen_reg  <= seen_next;
            end
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(wr_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (2'(i) < wr_n)
                fifo_mem[FIFO_AW'(wr_ptr_reg + FIFO_AW'(i))] <= slot[i];
        end
    end

endmodule

@@ src/tdcswd_checker.sv @@
// ----------------------------------------------------------------------------
// TDC sub-event word decoder checker
// Port-level assertions on the result stream of the decoder.
// ----------------------------------------------------------------------------
`include "tdc_subevent_word_decoder_macros.svh"

module tdcswd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tdcswd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [tdcswd_pkg::KIND_W-1:0]      m_tuser,
    input logic                               m_tlast
);
    import tdcswd_pkg::*;

    logic       meas_out;
    logic       other_out;
    logic       early_out;
    logic [2:0] data_tag;

    assign meas_out  = m_tvalid && (m_tuser == KIND_MEAS);
    assign other_out = m_tvalid && (m_tuser != KIND_MEAS);
    assign early_out = m_tvalid && (m_tuser == KIND_EARLY);
    assign data_tag  = m_tdata[127:125];

    `TDCSWD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "Result withdrawn")
    `TDCSWD_ASSERT(a_hit_tag, (meas_out |-> (data_tag == HIT_TAG[31:29])), "Hit tag missing")
    `TDCSWD_ASSERT(a_meas_zero, (other_out |-> (m_tdata[127:0] == '0)), "Block fields set")
    `TDCSWD_ASSERT(a_early_last, (early_out |-> m_tlast), "Early end is not last")

endmodule

bind tdc_subevent_word_decoder tdcswd_checker u_tdcswd_checker (.*);
